// ===== design/iau_pkg.sv =====
// shared types, widths and constants for the interval arithmetic unit
// no dependencies
`default_nettype none
package iau_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DW = 32 + FRAC_BITS;
    localparam int RW = 65;

    localparam logic signed [RW-1:0] S32_MAX_W = RW'(64'sh7FFF_FFFF);
    localparam logic signed [RW-1:0] S32_MIN_W = -S32_MAX_W - RW'(1);

    localparam logic [1:0] ORD_BELOW = 2'b11;
    localparam logic [1:0] ORD_NONE  = 2'b00;
    localparam logic [1:0] ORD_ABOVE = 2'b01;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_NEG  = 4'd4,
        CMD_ABS  = 4'd5,
        CMD_CMP  = 4'd6,
        CMD_MID  = 4'd7,
        CMD_HALF = 4'd8
    } t_cmd;

    typedef struct packed {
        logic [3:0]             cmd;
        logic signed [RW-1:0]   lo;
        logic signed [RW-1:0]   hi;
        logic [1:0]             ord;
        logic                   dz;
        logic [3:0]             neg;
    } t_ctl;
endpackage
`default_nettype wire

// ===== design/iau_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage, unsigned
// depends on iau_pkg for the dividend width
`default_nettype none
module iau_div_lane (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [iau_pkg::DW-1:0] i_num,
    input  wire logic [31:0]            i_den,
    output logic      [iau_pkg::DW-1:0] o_quo
);
    logic [31:0]            r_rem [iau_pkg::DW];
    logic [iau_pkg::DW-1:0] r_num [iau_pkg::DW];
    logic [iau_pkg::DW-1:0] r_quo [iau_pkg::DW];
    logic [31:0]            r_den [iau_pkg::DW];

    for (genvar k = 0; k < iau_pkg::DW; k++) begin : g_stage
        logic [31:0]            p_rem;
        logic [iau_pkg::DW-1:0] p_num;
        logic [iau_pkg::DW-1:0] p_quo;
        logic [31:0]            p_den;
        logic [32:0]            t;
        logic [32:0]            diff;
        logic                   bit_q;
        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
        end
        assign t     = {p_rem, p_num[iau_pkg::DW-1]};
        assign diff  = t - {1'b0, p_den};
        assign bit_q = (t >= {1'b0, p_den});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= bit_q ? diff[31:0] : t[31:0];
                r_num[k] <= p_num << 1;
                r_quo[k] <= {p_quo[iau_pkg::DW-2:0], bit_q};
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[iau_pkg::DW-1];
endmodule
`default_nettype wire

// ===== design/interval_arithmetic_unit_core.sv =====
// interval arithmetic unit top level: operand stage, multipliers,
// four divider lanes, min/max selection and saturation; uses iau_pkg, iau_div_lane
// throughput one transfer per cycle; the whole pipe holds while the output stalls
// synchronous active-low reset clears the valid bits only
`default_nettype none
module interval_arithmetic_unit_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_cmd,
    input  wire logic signed [31:0] i_a_lo,
    input  wire logic signed [31:0] i_a_hi,
    input  wire logic signed [31:0] i_b_lo,
    input  wire logic signed [31:0] i_b_hi,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_r_lo,
    output logic signed [31:0]      o_r_hi,
    output logic signed [1:0]       o_order,
    output logic [1:0]              o_status
);
    localparam int RW = iau_pkg::RW;
    localparam int DW = iau_pkg::DW;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // operand stage
    logic               r1_valid;
    logic [3:0]         r1_cmd;
    logic signed [31:0] r1_alo, r1_ahi, r1_blo, r1_bhi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
        if (en) begin
            r1_cmd <= i_cmd;
            r1_alo <= i_a_lo;
            r1_ahi <= i_a_hi;
            r1_blo <= i_b_lo;
            r1_bhi <= i_b_hi;
        end
    end

    // simple ops and divider setup
    iau_pkg::t_ctl n_ctl0;
    logic signed [32:0] alo_x, ahi_x, blo_x, bhi_x;
    logic [31:0] mag_alo, mag_ahi, mag_blo, mag_bhi;
    assign alo_x = 33'(r1_alo);
    assign ahi_x = 33'(r1_ahi);
    assign blo_x = 33'(r1_blo);
    assign bhi_x = 33'(r1_bhi);
    assign mag_alo = r1_alo[31] ? 32'(-alo_x) : r1_alo;
    assign mag_ahi = r1_ahi[31] ? 32'(-ahi_x) : r1_ahi;
    assign mag_blo = r1_blo[31] ? 32'(-blo_x) : r1_blo;
    assign mag_bhi = r1_bhi[31] ? 32'(-bhi_x) : r1_bhi;

    always_comb begin
        logic signed [32:0] t;
        t = '0;
        n_ctl0     = '0;
        n_ctl0.cmd = r1_cmd;
        n_ctl0.neg = {r1_ahi[31] ^ r1_bhi[31], r1_ahi[31] ^ r1_blo[31],
                      r1_alo[31] ^ r1_bhi[31], r1_alo[31] ^ r1_blo[31]};
        case (iau_pkg::t_cmd'(r1_cmd))
            iau_pkg::CMD_ADD: begin
                n_ctl0.lo = RW'(alo_x + blo_x);
                n_ctl0.hi = RW'(ahi_x + bhi_x);
            end
            iau_pkg::CMD_SUB: begin
                n_ctl0.lo = RW'(alo_x - bhi_x);
                n_ctl0.hi = RW'(ahi_x - blo_x);
            end
            iau_pkg::CMD_DIV: begin
                if ((r1_blo[31] || r1_blo == 32'sd0) && !r1_bhi[31]) begin
                    n_ctl0.dz = 1'b1;
                    n_ctl0.lo = iau_pkg::S32_MIN_W;
                    n_ctl0.hi = iau_pkg::S32_MAX_W;
                end
            end
            iau_pkg::CMD_NEG: begin
                n_ctl0.lo = RW'(-ahi_x);
                n_ctl0.hi = RW'(-alo_x);
            end
            iau_pkg::CMD_ABS: begin
                if (!r1_alo[31]) begin
                    n_ctl0.lo = RW'(alo_x);
                    n_ctl0.hi = RW'(ahi_x);
                end else if (r1_ahi[31] || r1_ahi == 32'sd0) begin
                    n_ctl0.lo = RW'(-ahi_x);
                    n_ctl0.hi = RW'(-alo_x);
                end else begin
                    n_ctl0.lo = '0;
                    n_ctl0.hi = (-alo_x > ahi_x) ? RW'(-alo_x) : RW'(ahi_x);
                end
            end
            iau_pkg::CMD_CMP: begin
                if (r1_ahi < r1_blo)      n_ctl0.ord = iau_pkg::ORD_BELOW;
                else if (r1_alo > r1_bhi) n_ctl0.ord = iau_pkg::ORD_ABOVE;
                else                      n_ctl0.ord = iau_pkg::ORD_NONE;
            end
            iau_pkg::CMD_MID: begin
                t = alo_x + ahi_x;
                n_ctl0.lo = RW'(t >>> 1);
            end
            iau_pkg::CMD_HALF: begin
                t = ahi_x - alo_x;
                n_ctl0.lo = RW'(t >>> 1);
            end
            default: begin
            end
        endcase
    end

    // control line alongside the dividers
    iau_pkg::t_ctl r_ctl [DW];
    logic          r_vld [DW];
    logic signed [63:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[0] <= r1_alo * r1_blo;
            r_prod[1] <= r1_alo * r1_bhi;
            r_prod[2] <= r1_ahi * r1_blo;
            r_prod[3] <= r1_ahi * r1_bhi;
        end
    end

    logic signed [RW-1:0] ps [4];
    logic signed [RW-1:0] pmin01, pmin23, pmax01, pmax23;
    iau_pkg::t_ctl n_ctl1;
    for (genvar i = 0; i < 4; i++) begin : g_ps
        assign ps[i] = RW'(r_prod[i] >>> iau_pkg::FRAC_BITS);
    end
    assign pmin01 = (ps[1] < ps[0]) ? ps[1] : ps[0];
    assign pmin23 = (ps[3] < ps[2]) ? ps[3] : ps[2];
    assign pmax01 = (ps[1] > ps[0]) ? ps[1] : ps[0];
    assign pmax23 = (ps[3] > ps[2]) ? ps[3] : ps[2];
    always_comb begin
        n_ctl1 = r_ctl[0];
        if (r_ctl[0].cmd == iau_pkg::CMD_MUL) begin
            n_ctl1.lo = (pmin23 < pmin01) ? pmin23 : pmin01;
            n_ctl1.hi = (pmax23 > pmax01) ? pmax23 : pmax01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DW; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r1_valid;
            for (int k = 1; k < DW; k++) r_vld[k] <= r_vld[k-1];
        end
        if (en) begin
            r_ctl[0] <= n_ctl0;
            r_ctl[1] <= n_ctl1;
            for (int k = 2; k < DW; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    logic [DW-1:0] quo [4];
    iau_div_lane u_div0 (.i_clk(i_clk), .i_en(en), .i_num(DW'(mag_alo) << iau_pkg::FRAC_BITS),
                         .i_den(mag_blo), .o_quo(quo[0]));
    iau_div_lane u_div1 (.i_clk(i_clk), .i_en(en), .i_num(DW'(mag_alo) << iau_pkg::FRAC_BITS),
                         .i_den(mag_bhi), .o_quo(quo[1]));
    iau_div_lane u_div2 (.i_clk(i_clk), .i_en(en), .i_num(DW'(mag_ahi) << iau_pkg::FRAC_BITS),
                         .i_den(mag_blo), .o_quo(quo[2]));
    iau_div_lane u_div3 (.i_clk(i_clk), .i_en(en), .i_num(DW'(mag_ahi) << iau_pkg::FRAC_BITS),
                         .i_den(mag_bhi), .o_quo(quo[3]));

    // signed quotients
    logic                 rd_valid;
    iau_pkg::t_ctl        rd_ctl;
    logic signed [RW-1:0] rd_q [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_valid <= 1'b0;
        end else if (en) begin
            rd_valid <= r_vld[DW-1];
        end
        if (en) begin
            rd_ctl <= r_ctl[DW-1];
            for (int i = 0; i < 4; i++) begin
                rd_q[i] <= r_ctl[DW-1].neg[i] ? -$signed(RW'(quo[i])) : $signed(RW'(quo[i]));
            end
        end
    end

    // quotient min/max
    logic signed [RW-1:0] qmin01, qmin23, qmax01, qmax23;
    assign qmin01 = (rd_q[1] < rd_q[0]) ? rd_q[1] : rd_q[0];
    assign qmin23 = (rd_q[3] < rd_q[2]) ? rd_q[3] : rd_q[2];
    assign qmax01 = (rd_q[1] > rd_q[0]) ? rd_q[1] : rd_q[0];
    assign qmax23 = (rd_q[3] > rd_q[2]) ? rd_q[3] : rd_q[2];

    logic                 re_valid;
    iau_pkg::t_ctl        re_ctl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_valid <= 1'b0;
        end else if (en) begin
            re_valid <= rd_valid;
        end
        if (en) begin
            re_ctl <= rd_ctl;
            if (rd_ctl.cmd == iau_pkg::CMD_DIV && !rd_ctl.dz) begin
                re_ctl.lo <= (qmin23 < qmin01) ? qmin23 : qmin01;
                re_ctl.hi <= (qmax23 > qmax01) ? qmax23 : qmax01;
            end
        end
    end

    // saturation and output register
    logic sat_lo_hi, sat_lo_lo, sat_hi_hi, sat_hi_lo;
    assign sat_lo_hi = re_ctl.lo > iau_pkg::S32_MAX_W;
    assign sat_lo_lo = re_ctl.lo < iau_pkg::S32_MIN_W;
    assign sat_hi_hi = re_ctl.hi > iau_pkg::S32_MAX_W;
    assign sat_hi_lo = re_ctl.hi < iau_pkg::S32_MIN_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= re_valid;
        end
        if (en) begin
            o_r_lo  <= sat_lo_hi ? 32'sh7FFF_FFFF : sat_lo_lo ? 32'sh8000_0000
                                 : re_ctl.lo[31:0];
            o_r_hi  <= sat_hi_hi ? 32'sh7FFF_FFFF : sat_hi_lo ? 32'sh8000_0000
                                 : re_ctl.hi[31:0];
            o_order <= re_ctl.ord;
            if (re_ctl.dz)
                o_status <= iau_pkg::ST_DIVZ;
            else if (sat_lo_hi || sat_lo_lo || sat_hi_hi || sat_hi_lo)
                o_status <= iau_pkg::ST_SAT;
            else
                o_status <= iau_pkg::ST_OK;
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("status code out of range");
    a_divz_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == iau_pkg::ST_DIVZ) |->
        (o_r_lo == 32'sh8000_0000 && o_r_hi == 32'sh7FFF_FFFF))
        else $error("divide by zero range wrong");
    a_order_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_order != iau_pkg::ORD_NONE) |->
        (o_r_lo == 32'sd0 && o_r_hi == 32'sd0 && o_status == iau_pkg::ST_OK))
        else $error("compare result with nonzero bounds");
endmodule
`default_nettype wire

// ===== verif/tb_interval_arithmetic_unit_core.sv =====
// testbench for interval_arithmetic_unit_core: queue-fed driver, clocked monitor
// and an interval predictor checked field by field; depends on iau_pkg and the core
`timescale 1ns / 1ps
module tb_interval_arithmetic_unit_core;

    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] a_lo, a_hi, b_lo, b_hi;
    } t_op;

    typedef struct {
        logic signed [31:0] r_lo, r_hi;
        logic [1:0]         order, status;
    } t_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic [3:0] i_cmd = 0;
    logic signed [31:0] i_a_lo = 0, i_a_hi = 0, i_b_lo = 0, i_b_hi = 0;
    logic o_stall, o_valid;
    logic signed [31:0] o_r_lo, o_r_hi;
    logic signed [1:0] o_order;
    logic [1:0] o_status;

    t_op  pending_ops[$];
    t_res expected_results[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0, stall_pct = 0;
    bit   hold_sender = 0;

    interval_arithmetic_unit_core uut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    function automatic logic signed [63:0] floor_div2n(logic signed [63:0] v);
        return v >>> iau_pkg::FRAC_BITS;
    endfunction

    function automatic t_res predict_interval(t_op op);
        t_res r;
        logic signed [63:0] alo, ahi, blo, bhi, lo, hi;
        logic signed [63:0] v[4];
        bit sat;
        alo = op.a_lo; ahi = op.a_hi; blo = op.b_lo; bhi = op.b_hi;
        lo = 0; hi = 0; r.order = iau_pkg::ORD_NONE; r.status = iau_pkg::ST_OK; sat = 0;
        case (op.cmd)
            iau_pkg::CMD_ADD: begin lo = alo + blo; hi = ahi + bhi; end
            iau_pkg::CMD_SUB: begin lo = alo - bhi; hi = ahi - blo; end
            iau_pkg::CMD_MUL: begin
                v[0] = floor_div2n(alo * blo); v[1] = floor_div2n(alo * bhi);
                v[2] = floor_div2n(ahi * blo); v[3] = floor_div2n(ahi * bhi);
                lo = v[0]; hi = v[0];
                for (int i = 1; i < 4; i++) begin
                    if (v[i] < lo) lo = v[i];
                    if (v[i] > hi) hi = v[i];
                end
            end
            iau_pkg::CMD_DIV: begin
                if (blo <= 0 && bhi >= 0) begin
                    lo = -64'sd2147483648; hi = 64'sd2147483647;
                    r.status = iau_pkg::ST_DIVZ;
                end else begin
                    v[0] = (alo <<< iau_pkg::FRAC_BITS) / blo;
                    v[1] = (alo <<< iau_pkg::FRAC_BITS) / bhi;
                    v[2] = (ahi <<< iau_pkg::FRAC_BITS) / blo;
                    v[3] = (ahi <<< iau_pkg::FRAC_BITS) / bhi;
                    lo = v[0]; hi = v[0];
                    for (int i = 1; i < 4; i++) begin
                        if (v[i] < lo) lo = v[i];
                        if (v[i] > hi) hi = v[i];
                    end
                end
            end
            iau_pkg::CMD_NEG: begin lo = -ahi; hi = -alo; end
            iau_pkg::CMD_ABS: begin
                if (alo >= 0) begin
                    lo = alo; hi = ahi;
                end else if (ahi <= 0) begin
                    lo = -ahi; hi = -alo;
                end else begin
                    lo = 0; hi = (-alo > ahi) ? -alo : ahi;
                end
            end
            iau_pkg::CMD_CMP: begin
                if (ahi < blo) r.order = iau_pkg::ORD_BELOW;
                else if (alo > bhi) r.order = iau_pkg::ORD_ABOVE;
            end
            iau_pkg::CMD_MID:  lo = (alo + ahi) >>> 1;
            iau_pkg::CMD_HALF: lo = (ahi - alo) >>> 1;
            default: ;
        endcase
        if (lo > 64'sd2147483647) begin lo = 64'sd2147483647; sat = 1; end
        if (lo < -64'sd2147483648) begin lo = -64'sd2147483648; sat = 1; end
        if (hi > 64'sd2147483647) begin hi = 64'sd2147483647; sat = 1; end
        if (hi < -64'sd2147483648) begin hi = -64'sd2147483648; sat = 1; end
        if (sat && r.status == iau_pkg::ST_OK) r.status = iau_pkg::ST_SAT;
        r.r_lo = lo[31:0]; r.r_hi = hi[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function automatic logic signed [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            3: return $signed($urandom_range(0, 8)) - 4;
            4: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            5: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op make_op(logic [3:0] cmd);
        t_op op;
        logic signed [31:0] t;
        op.cmd = cmd;
        op.a_lo = pick_bound(); op.a_hi = pick_bound();
        op.b_lo = pick_bound(); op.b_hi = pick_bound();
        // mostly well-ordered intervals, never a reversed divisor with a zero end
        if ($urandom_range(0, 9) < 8 ||
            (cmd == iau_pkg::CMD_DIV && (op.b_lo == 0 || op.b_hi == 0))) begin
            if (op.a_lo > op.a_hi) begin t = op.a_lo; op.a_lo = op.a_hi; op.a_hi = t; end
            if (op.b_lo > op.b_hi) begin t = op.b_lo; op.b_lo = op.b_hi; op.b_hi = t; end
        end
        return op;
    endfunction

    function automatic t_op direct_op(logic [3:0] c, logic signed [31:0] al,
                                      logic signed [31:0] ah, logic signed [31:0] bl,
                                      logic signed [31:0] bh);
        t_op op;
        op.cmd = c; op.a_lo = al; op.a_hi = ah; op.b_lo = bl; op.b_hi = bh;
        return op;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || !o_stall) begin
            if (pending_ops.size() > 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1;
                i_cmd   <= pending_ops[0].cmd;
                i_a_lo  <= pending_ops[0].a_lo;
                i_a_hi  <= pending_ops[0].a_hi;
                i_b_lo  <= pending_ops[0].b_lo;
                i_b_hi  <= pending_ops[0].b_hi;
                expected_results.push_back(predict_interval(pending_ops.pop_front()));
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", o_r_lo, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_r_lo !== want.r_lo) report_mismatch("r_lo", o_r_lo, want.r_lo);
                    if (o_r_hi !== want.r_hi) report_mismatch("r_hi", o_r_hi, want.r_hi);
                    if (o_order !== want.order)
                        report_mismatch("order", o_order, want.order);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] mn, mx;
        mn = 32'sh8000_0000; mx = 32'sh7FFF_FFFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every opcode, zero divisors, abs straddle, reversed, unused
        pending_ops.push_back(direct_op(iau_pkg::CMD_ADD, mx, mx, mx, mx));
        pending_ops.push_back(direct_op(iau_pkg::CMD_ADD, mn, mn, mn, mn));
        pending_ops.push_back(direct_op(iau_pkg::CMD_SUB, mn, mx, mn, mx));
        pending_ops.push_back(direct_op(iau_pkg::CMD_SUB, 32'sh10000, 32'sh20000,
                                        32'sh8000, 32'sh9000));
        pending_ops.push_back(direct_op(iau_pkg::CMD_MUL, mn, mx, mn, mx));
        pending_ops.push_back(direct_op(iau_pkg::CMD_MUL, -3, 5, -7, 2));
        pending_ops.push_back(direct_op(iau_pkg::CMD_MUL, 32'sh18000, 32'sh28000,
                                        -32'sh8000, 32'sh30000));
        pending_ops.push_back(direct_op(iau_pkg::CMD_DIV, 32'sh10000, 32'sh20000,
                                        0, 32'sh10000));
        pending_ops.push_back(direct_op(iau_pkg::CMD_DIV, 32'sh10000, 32'sh20000,
                                        -32'sh10000, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_DIV, mn, mx, 1, 1));
        pending_ops.push_back(direct_op(iau_pkg::CMD_DIV, mn, mx, -1, -1));
        pending_ops.push_back(direct_op(iau_pkg::CMD_DIV, -32'sh30000, 32'sh50000,
                                        32'sh20000, 32'sh40000));
        pending_ops.push_back(direct_op(iau_pkg::CMD_NEG, mn, mn, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_NEG, -5, 9, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_ABS, -9, 5, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_ABS, mn, -1, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_ABS, 3, 8, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_CMP, 1, 2, 3, 4));
        pending_ops.push_back(direct_op(iau_pkg::CMD_CMP, 5, 6, 3, 4));
        pending_ops.push_back(direct_op(iau_pkg::CMD_CMP, 1, 3, 3, 4));
        pending_ops.push_back(direct_op(iau_pkg::CMD_MID, mx, mx, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_MID, -3, 0, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_HALF, mn, mx, 0, 0));
        pending_ops.push_back(direct_op(iau_pkg::CMD_HALF, 9, 2, 0, 0));
        pending_ops.push_back(direct_op(4'd15, mx, mn, mx, mn));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            for (int n = 0; n < 270; n++)
                pending_ops.push_back(make_op($urandom_range(0, 9) == 0 ?
                    4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8))));
            if (phase == 2) begin
                while (pending_ops.size() > 140) @(posedge i_clk);
                hold_sender = 1;
                while (expected_results.size() > 0 || i_valid) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end
        repeat (LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
